// ===== rtl/core/stdc_pkg.sv =====
// Package with the constants and codes of the system tick down counter.
`default_nettype none

package stdc_pkg;

  localparam int COUNTER_BITS     = 24;
  localparam int REFERENCE_DIVIDE = 8;
  localparam int PRESCALE_BITS    = $clog2(REFERENCE_DIVIDE);
  localparam int DATA_BITS        = 24;

  localparam int CTRL_ENABLE_BIT  = 0;
  localparam int CTRL_INT_BIT     = 1;
  localparam int CTRL_CLKSRC_BIT  = 2;
  localparam int CTRL_FLAG_BIT    = 16;

  typedef logic [COUNTER_BITS-1:0]  count_t;
  typedef logic [PRESCALE_BITS-1:0] prescale_t;
  typedef logic [DATA_BITS-1:0]     data_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_CTRL    = 2'd0,
    REG_RELOAD  = 2'd1,
    REG_CURRENT = 2'd2,
    REG_ELAPSED = 2'd3
  } reg_sel_t;

endpackage

`default_nettype wire

// ===== rtl/core/system_tick_down_counter.sv =====
// Top level of the system tick down counter with its request pipeline.
//
// Each request on the input channel (in_valid, in_ready) is a clock tick, a
// register read, a register write or a no-op, selected by action, reg_select and
// write_data. Each request yields exactly one response on the output channel
// (out_valid, out_ready): read_data carries the register contents on reads,
// interrupt_request is high when a tick brought the counter to zero with
// interrupts enabled.
// The request goes into an input register; the timer state is updated and the
// response is formed from it and held in an output register once that register
// is free. One request is accepted in every cycle while the receiver does not
// stall; the throughput is set by the single state update between the input
// and output registers.
// When the receiver stalls, the output register holds its response and the
// input register fills; in_ready then drops until the response is taken.
// The cfg channel (cfg_valid, cfg_ready, one_shot) sets one-shot mode and is
// always ready. Synchronous reset clears all timer state and the valid flags of
// both pipeline stages.
`default_nettype none

module system_tick_down_counter
  import stdc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           action,
  input  wire logic [1:0]           reg_select,
  input  wire logic [DATA_BITS-1:0] write_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [DATA_BITS-1:0]      read_data,
  output logic                      interrupt_request,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 one_shot
);

  logic      req_valid;
  action_t   req_action;
  reg_sel_t  req_sel;
  data_t     req_data;

  count_t    current_count, current_count_next;
  count_t    reload_value, reload_value_next;
  logic      counter_enable, counter_enable_next;
  logic      interrupt_enable, interrupt_enable_next;
  logic      clock_select, clock_select_next;
  logic      count_flag, count_flag_next;
  prescale_t prescale_count, prescale_count_next;
  logic      one_shot_mode;

  logic      advance;
  data_t     rd_next;
  logic      irq_next;
  logic      tick_event;
  count_t    count_dec;
  count_t    elapsed;

  assign advance   = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || advance;
  assign cfg_ready = 1'b1;

  assign count_dec = current_count - count_t'(1);
  assign elapsed   = reload_value - current_count;

  always_comb begin
    current_count_next    = current_count;
    reload_value_next     = reload_value;
    counter_enable_next   = counter_enable;
    interrupt_enable_next = interrupt_enable;
    clock_select_next     = clock_select;
    count_flag_next       = count_flag;
    prescale_count_next   = prescale_count;
    rd_next               = '0;
    irq_next              = 1'b0;
    tick_event            = 1'b0;
    unique case (req_action)
      ACT_TICK: begin
        if (prescale_count == prescale_t'(REFERENCE_DIVIDE - 1)) begin
          prescale_count_next = '0;
        end else begin
          prescale_count_next = prescale_count + prescale_t'(1);
        end
        tick_event = clock_select || (prescale_count_next == '0);
        if (counter_enable && tick_event) begin
          if (current_count == '0) begin
            current_count_next = reload_value;
          end else begin
            current_count_next = count_dec;
            if (count_dec == '0) begin
              count_flag_next = 1'b1;
              if (interrupt_enable) begin
                irq_next = 1'b1;
                if (one_shot_mode) begin
                  counter_enable_next   = 1'b0;
                  interrupt_enable_next = 1'b0;
                  current_count_next    = '0;
                end
              end
            end
          end
        end
      end
      ACT_READ: begin
        unique case (req_sel)
          REG_CTRL: begin
            rd_next[CTRL_ENABLE_BIT] = counter_enable;
            rd_next[CTRL_INT_BIT]    = interrupt_enable;
            rd_next[CTRL_CLKSRC_BIT] = clock_select;
            rd_next[CTRL_FLAG_BIT]   = count_flag;
            count_flag_next          = 1'b0;
          end
          REG_RELOAD:  rd_next = data_t'(reload_value);
          REG_CURRENT: rd_next = data_t'(current_count);
          REG_ELAPSED: rd_next = data_t'(elapsed);
          default:     rd_next = '0;
        endcase
      end
      ACT_WRITE: begin
        unique case (req_sel)
          REG_CTRL: begin
            counter_enable_next   = req_data[CTRL_ENABLE_BIT];
            interrupt_enable_next = req_data[CTRL_INT_BIT];
            clock_select_next     = req_data[CTRL_CLKSRC_BIT];
          end
          REG_RELOAD:  reload_value_next = count_t'(req_data);
          REG_CURRENT: begin
            current_count_next = '0;
            count_flag_next    = 1'b0;
          end
          REG_ELAPSED: ;
          default: ;
        endcase
      end
      ACT_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid        <= 1'b0;
      out_valid        <= 1'b0;
      current_count    <= '0;
      reload_value     <= '0;
      counter_enable   <= 1'b0;
      interrupt_enable <= 1'b0;
      clock_select     <= 1'b0;
      count_flag       <= 1'b0;
      prescale_count   <= '0;
      one_shot_mode    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        one_shot_mode <= one_shot;
      end
      if (in_ready) begin
        req_valid <= in_valid;
      end
      if (advance) begin
        out_valid        <= 1'b1;
        current_count    <= current_count_next;
        reload_value     <= reload_value_next;
        counter_enable   <= counter_enable_next;
        interrupt_enable <= interrupt_enable_next;
        clock_select     <= clock_select_next;
        count_flag       <= count_flag_next;
        prescale_count   <= prescale_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_action <= action_t'(action);
      req_sel    <= reg_sel_t'(reg_select);
      req_data   <= write_data;
    end
    if (advance) begin
      read_data         <= rd_next;
      interrupt_request <= irq_next;
    end
  end

endmodule

`default_nettype wire
